// File: rtl/pws_pkg.sv
// ----------------------------------------------------------------------------
// Pulse waveform source package
// Shared widths, configuration register indexes and the control bundles that
// travel along the remainder and ramp quotient pipelines.
// ----------------------------------------------------------------------------
package pws_pkg;

  // Field widths.
  localparam int StepW    = 32;
  localparam int TickW    = 24;
  localparam int VoltW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int ProdW    = VoltW + TickW;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE     = 3'd0,
    REG_V_LOW    = 3'd1,
    REG_V_HIGH   = 3'd2,
    REG_DELAY    = 3'd3,
    REG_RISE     = 3'd4,
    REG_FALL     = 3'd5,
    REG_ON       = 3'd6,
    REG_PERIOD   = 3'd7
  } cfg_idx_e;

  // Control carried along the phase remainder pipeline.
  typedef struct packed {
    logic valid;
    logic bypass;
  } rem_ctl_t;

  // Control carried along the ramp quotient pipeline.
  typedef struct packed {
    logic             valid;
    logic             ramp;
    logic             neg;
    logic             fall;
    logic [VoltW-1:0] base;
  } quo_ctl_t;

endpackage

// File: rtl/pws_rem_pipe.sv
// ----------------------------------------------------------------------------
// Phase remainder pipeline
// Restoring division with one dividend bit per stage; gives the remainder of
// a 32-bit step offset by the 24-bit period. The whole pipe holds on a stall.
// ----------------------------------------------------------------------------
module pws_rem_pipe
  import pws_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  rem_ctl_t         ctl_i,
  input  logic [StepW-1:0] dividend_i,
  input  logic [TickW-1:0] divisor_i,
  output rem_ctl_t         ctl_o,
  output logic [TickW-1:0] rem_o
);

  localparam int NStg = StepW;

  rem_ctl_t         ctl_d [NStg];
  rem_ctl_t         ctl_q [NStg];
  logic [TickW-1:0] rem_d [NStg];
  logic [TickW-1:0] rem_q [NStg];
  logic [StepW-1:0] num_d [NStg-1];
  logic [StepW-1:0] num_q [NStg-1];

  // One remainder step per stage: shift in the next dividend bit, subtract
  // the divisor when it fits.
  for (genvar k = 0; k < NStg; k++) begin : g_stg
    logic [TickW-1:0] rem_in;
    logic [StepW-1:0] num_in;
    rem_ctl_t         ctl_in;
    logic [TickW:0]   trial;
    logic [TickW:0]   diff;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = dividend_i;
      assign ctl_in = ctl_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign ctl_in = ctl_q[k-1];
    end

    assign trial    = {rem_in, num_in[StepW-1]};
    assign diff     = trial - {1'b0, divisor_i};
    assign rem_d[k] = (trial >= {1'b0, divisor_i}) ? diff[TickW-1:0] : trial[TickW-1:0];
    assign ctl_d[k] = ctl_in;

    if (k < NStg - 1) begin : g_num
      assign num_d[k] = {num_in[StepW-2:0], 1'b0};
    end
  end

  // Stage control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NStg; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (en_i) begin
      for (int k = 0; k < NStg; k++) begin
        ctl_q[k] <= ctl_d[k];
      end
    end
  end

  // Stage data registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NStg; k++) begin
        rem_q[k] <= rem_d[k];
      end
      for (int k = 0; k < NStg - 1; k++) begin
        num_q[k] <= num_d[k];
      end
    end
  end

  assign ctl_o = ctl_q[NStg-1];
  assign rem_o = rem_q[NStg-1];

endmodule

// File: rtl/pws_quo_pipe.sv
// ----------------------------------------------------------------------------
// Ramp quotient pipeline
// Divides the 40-bit ramp product by the rise or fall length, one quotient
// bit per stage. The product is below 2^16 times the divisor, so its upper
// 24 bits start as the partial remainder and 16 steps finish the quotient.
// ----------------------------------------------------------------------------
module pws_quo_pipe
  import pws_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  quo_ctl_t         ctl_i,
  input  logic [ProdW-1:0] prod_i,
  input  logic [TickW-1:0] rise_i,
  input  logic [TickW-1:0] fall_i,
  output quo_ctl_t         ctl_o,
  output logic [VoltW-1:0] quo_o
);

  localparam int NStg = VoltW;

  quo_ctl_t         ctl_d [NStg];
  quo_ctl_t         ctl_q [NStg];
  logic [VoltW-1:0] low_d [NStg];
  logic [VoltW-1:0] low_q [NStg];
  logic [TickW-1:0] rem_d [NStg-1];
  logic [TickW-1:0] rem_q [NStg-1];

  // One quotient bit per stage; the low product bits shift out as the
  // quotient bits shift in.
  for (genvar k = 0; k < NStg; k++) begin : g_stg
    logic [TickW-1:0] rem_in;
    logic [VoltW-1:0] low_in;
    quo_ctl_t         ctl_in;
    logic [TickW-1:0] den;
    logic [TickW:0]   trial;
    logic [TickW:0]   diff;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in = prod_i[ProdW-1:VoltW];
      assign low_in = prod_i[VoltW-1:0];
      assign ctl_in = ctl_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign ctl_in = ctl_q[k-1];
    end

    assign den      = ctl_in.fall ? fall_i : rise_i;
    assign trial    = {rem_in, low_in[VoltW-1]};
    assign diff     = trial - {1'b0, den};
    assign fits     = (trial >= {1'b0, den});
    assign low_d[k] = {low_in[VoltW-2:0], fits};
    assign ctl_d[k] = ctl_in;

    if (k < NStg - 1) begin : g_rem
      assign rem_d[k] = fits ? diff[TickW-1:0] : trial[TickW-1:0];
    end
  end

  // Stage control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NStg; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (en_i) begin
      for (int k = 0; k < NStg; k++) begin
        ctl_q[k] <= ctl_d[k];
      end
    end
  end

  // Stage data registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NStg; k++) begin
        low_q[k] <= low_d[k];
      end
      for (int k = 0; k < NStg - 1; k++) begin
        rem_q[k] <= rem_d[k];
      end
    end
  end

  assign ctl_o = ctl_q[NStg-1];
  assign quo_o = low_q[NStg-1];

endmodule

// File: rtl/pulse_waveform_source.sv
// Pipeline: 32 phase remainder stages, classify, multiply, 16 ramp quotient
// stages, final add and output register lie between the input transfer and
// voltage_o.
// Throughput: one step per cycle while the skid entry is free; an output register plus one skid entry hold
// results while the consumer stalls, and the pipeline freezes once both fill.
// Reset clears all configuration registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
// Pulse waveform source
// Gives the trapezoidal pulse voltage, or the DC level, for each step index.
// ----------------------------------------------------------------------------
module pulse_waveform_source
  import pws_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [StepW-1:0]    step_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [VoltW-1:0]    voltage_o
);

  // Configuration registers.
  logic             mode_q;
  logic [VoltW-1:0] v_low_q;
  logic [VoltW-1:0] v_high_q;
  logic [TickW-1:0] delay_q;
  logic [TickW-1:0] rise_q;
  logic [TickW-1:0] fall_q;
  logic [TickW-1:0] on_q;
  logic [TickW-1:0] period_q;

  // Values derived from the configuration.
  logic [TickW:0]   ro_q;
  logic [TickW+1:0] rof_q;
  logic [VoltW-1:0] span_mag_q;
  logic             span_neg_q;
  logic [VoltW:0]   span_up;

  // Pipeline control.
  logic             en;
  logic             in_xfer;
  rem_ctl_t         in_ctl;
  logic [StepW-1:0] step_off;
  rem_ctl_t         rem_ctl;
  logic [TickW-1:0] rem_phase;

  // Classify stage.
  quo_ctl_t         c_ctl_d;
  quo_ctl_t         c_ctl_q;
  logic [VoltW-1:0] c_mag_d;
  logic [VoltW-1:0] c_mag_q;
  logic [TickW-1:0] c_off_d;
  logic [TickW-1:0] c_off_q;
  logic [TickW:0]   fall_off;

  // Multiply stage.
  quo_ctl_t         m_ctl_q;
  logic [ProdW-1:0] m_prod_q;

  // Quotient output, final stage and output buffering.
  quo_ctl_t         quo_ctl;
  logic [VoltW-1:0] quo;
  logic [VoltW-1:0] f_volt_d;
  logic             f_valid_q;
  logic [VoltW-1:0] f_volt_q;
  logic             out_valid_q;
  logic [VoltW-1:0] out_volt_q;
  logic             skid_valid_q;
  logic [VoltW-1:0] skid_volt_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      v_low_q  <= '0;
      v_high_q <= '0;
      delay_q  <= '0;
      rise_q   <= '0;
      fall_q   <= '0;
      on_q     <= '0;
      period_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_MODE:   mode_q   <= cfg_wdata_i[0];
        REG_V_LOW:  v_low_q  <= cfg_wdata_i[VoltW-1:0];
        REG_V_HIGH: v_high_q <= cfg_wdata_i[VoltW-1:0];
        REG_DELAY:  delay_q  <= cfg_wdata_i[TickW-1:0];
        REG_RISE:   rise_q   <= cfg_wdata_i[TickW-1:0];
        REG_FALL:   fall_q   <= cfg_wdata_i[TickW-1:0];
        REG_ON:     on_q     <= cfg_wdata_i[TickW-1:0];
        REG_PERIOD: period_q <= cfg_wdata_i[TickW-1:0];
      endcase
    end
  end

  // Segment bounds and the ramp span follow the configuration in the next cycle,
  // long before any item reaches the classify stage.
  assign span_up = {v_high_q[VoltW-1], v_high_q} - {v_low_q[VoltW-1], v_low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ro_q       <= '0;
      rof_q      <= '0;
      span_mag_q <= '0;
      span_neg_q <= 1'b0;
    end else begin
      ro_q       <= {1'b0, rise_q} + {1'b0, on_q};
      rof_q      <= {2'b0, rise_q} + {2'b0, on_q} + {2'b0, fall_q};
      span_neg_q <= span_up[VoltW];
      span_mag_q <= span_up[VoltW] ? VoltW'((VoltW+1)'(0) - span_up) : span_up[VoltW-1:0];
    end
  end

  // The pipeline advances as long as the skid entry is free.
  assign en         = !skid_valid_q;
  assign in_ready_o = en;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Entry: steps before the delay, a zero period and DC mode all give the
  // low level.
  assign in_ctl.valid  = in_xfer;
  assign in_ctl.bypass = !mode_q || (period_q == '0) || (step_index_i < {8'b0, delay_q});
  assign step_off      = step_index_i - {8'b0, delay_q};

  pws_rem_pipe u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .ctl_i      (in_ctl),
    .dividend_i (step_off),
    .divisor_i  (period_q),
    .ctl_o      (rem_ctl),
    .rem_o      (rem_phase)
  );

  // Classify the phase into rise, plateau, fall or low.
  assign fall_off = {1'b0, rem_phase} - ro_q;

  always_comb begin
    c_ctl_d.valid = rem_ctl.valid;
    c_ctl_d.ramp  = 1'b0;
    c_ctl_d.neg   = 1'b0;
    c_ctl_d.fall  = 1'b0;
    c_ctl_d.base  = v_low_q;
    c_mag_d       = '0;
    c_off_d       = '0;
    if (!rem_ctl.bypass) begin
      if (rem_phase < rise_q) begin
        c_ctl_d.ramp = 1'b1;
        c_ctl_d.neg  = span_neg_q;
        c_mag_d      = span_mag_q;
        c_off_d      = rem_phase;
      end else if ({1'b0, rem_phase} < ro_q) begin
        c_ctl_d.base = v_high_q;
      end else if ({2'b0, rem_phase} < rof_q) begin
        c_ctl_d.ramp = 1'b1;
        c_ctl_d.neg  = !span_neg_q;
        c_ctl_d.fall = 1'b1;
        c_ctl_d.base = v_high_q;
        c_mag_d      = span_mag_q;
        c_off_d      = fall_off[TickW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_ctl_q <= '0;
      m_ctl_q <= '0;
    end else if (en) begin
      c_ctl_q <= c_ctl_d;
      m_ctl_q <= c_ctl_q;
    end
  end

  // Ramp magnitude times offset into the segment.
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_mag_q  <= c_mag_d;
      c_off_q  <= c_off_d;
      m_prod_q <= ProdW'(c_mag_q) * ProdW'(c_off_q);
    end
  end

  pws_quo_pipe u_quo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (m_ctl_q),
    .prod_i (m_prod_q),
    .rise_i (rise_q),
    .fall_i (fall_q),
    .ctl_o  (quo_ctl),
    .quo_o  (quo)
  );

  // Apply the truncated ramp step to the segment base; the true value always
  // lies between the two levels, so 16-bit wrap arithmetic is exact.
  always_comb begin
    if (!quo_ctl.ramp) begin
      f_volt_d = quo_ctl.base;
    end else if (quo_ctl.neg) begin
      f_volt_d = quo_ctl.base - quo;
    end else begin
      f_volt_d = quo_ctl.base + quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= quo_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_volt_q <= f_volt_d;
    end
  end

  // Output register with one skid entry; a result leaving the final stage
  // goes to the skid entry when the output register is held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_volt_q   <= '0;
      skid_valid_q <= 1'b0;
      skid_volt_q  <= '0;
    end else if (skid_valid_q) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_q  <= 1'b1;
        out_volt_q   <= skid_volt_q;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= f_valid_q;
      out_volt_q  <= f_volt_q;
    end else if (f_valid_q) begin
      skid_valid_q <= 1'b1;
      skid_volt_q  <= f_volt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign voltage_o   = out_volt_q;

  // The skid entry only fills behind a held output register.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output register is empty");

  // A live phase is always inside the period.
  a_phase_in_period : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_ctl.valid && !rem_ctl.bypass) |-> (rem_phase < period_q))
    else $error("phase remainder not below the period");

  // A result arriving at a held output register is caught by the skid entry.
  a_skid_catches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid_q && !skid_valid_q && out_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("result lost while the output was stalled");

endmodule

// File: verif/pws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse waveform source checker
// Watches the configuration port and the step and voltage channels. It keeps
// its own copy of the registers, predicts the voltage for every step transfer,
// and compares each voltage transfer with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module pws_checker
  import pws_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [StepW-1:0]    step_index_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [VoltW-1:0]    voltage_i,
  output int                  mismatch_count_o,
  output int                  pending_count_o
);

  // Shadow copy of the configuration registers.
  logic                    pulse_mode;
  logic signed [VoltW-1:0] level_low;
  logic signed [VoltW-1:0] level_high;
  logic [TickW-1:0]        delay_len;
  logic [TickW-1:0]        rise_len;
  logic [TickW-1:0]        fall_len;
  logic [TickW-1:0]        on_len;
  logic [TickW-1:0]        period_len;

  // Predicted voltages in transfer order.
  logic [VoltW-1:0] voltage_fifo[$];
  int               mismatches;

  // Trapezoid voltage for one step index under the current register copy.
  // All arithmetic is done in 64 bits; ramp division truncates toward zero.
  function automatic logic [VoltW-1:0] source_voltage(input logic [StepW-1:0] step);
    longint phase;
    longint span;
    longint level;
    longint rise_end;
    longint on_end;
    longint fall_end;
    level = longint'(level_low);
    if (pulse_mode && period_len != '0 && step >= delay_len) begin
      phase    = (longint'(step) - longint'(delay_len)) % longint'(period_len);
      rise_end = longint'(rise_len);
      on_end   = rise_end + longint'(on_len);
      fall_end = on_end + longint'(fall_len);
      if (phase < rise_end) begin
        span  = longint'(level_high) - longint'(level_low);
        level = longint'(level_low) + (span * phase) / longint'(rise_len);
      end else if (phase < on_end) begin
        level = longint'(level_high);
      end else if (phase < fall_end) begin
        span  = longint'(level_low) - longint'(level_high);
        level = longint'(level_high) + (span * (phase - on_end)) / longint'(fall_len);
      end
    end
    return level[VoltW-1:0];
  endfunction

  // Compare finished results, queue new predictions, track register writes.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [VoltW-1:0] predicted;
    if (!rst_ni) begin
      pulse_mode = 1'b0;
      level_low  = '0;
      level_high = '0;
      delay_len  = '0;
      rise_len   = '0;
      fall_len   = '0;
      on_len     = '0;
      period_len = '0;
      voltage_fifo.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (voltage_fifo.size() == 0) begin
          $error("voltage: unexpected transfer, actual %0d", $signed(voltage_i));
          mismatches++;
        end else begin
          predicted = voltage_fifo.pop_front();
          if (voltage_i !== predicted) begin
            $error("voltage mismatch: expected %0d, actual %0d",
                   $signed(predicted), $signed(voltage_i));
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        voltage_fifo = {voltage_fifo, source_voltage(step_index_i)};
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          REG_MODE:   pulse_mode = cfg_wdata_i[0];
          REG_V_LOW:  level_low  = cfg_wdata_i[VoltW-1:0];
          REG_V_HIGH: level_high = cfg_wdata_i[VoltW-1:0];
          REG_DELAY:  delay_len  = cfg_wdata_i[TickW-1:0];
          REG_RISE:   rise_len   = cfg_wdata_i[TickW-1:0];
          REG_FALL:   fall_len   = cfg_wdata_i[TickW-1:0];
          REG_ON:     on_len     = cfg_wdata_i[TickW-1:0];
          REG_PERIOD: period_len = cfg_wdata_i[TickW-1:0];
          default: ;
        endcase
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= voltage_fifo.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse waveform source testbench
// Drives register settings and step indexes into the source, with random
// bursts on the step side and random stalls on the voltage side, and gives
// the verdict from the checker's mismatch count and leftover predictions.
// ----------------------------------------------------------------------------
module tb;
  import pws_pkg::*;

  localparam int RandomItems = 1550;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 60;
  localparam int StallLimit  = 5000;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i  = REG_MODE;
  logic [CfgDataW-1:0] cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [StepW-1:0]    step_index_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [VoltW-1:0]    voltage_o;

  int               fail_total;
  int               volts_pending;
  int               stall_cycles = 0;
  int               burst_left   = 0;
  int               steps_sent   = 0;
  bit               hold_req     = 1'b0;
  logic [TickW-1:0] cur_delay    = '0;
  logic [TickW-1:0] cur_period   = '0;

  pulse_waveform_source uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .step_index_i(step_index_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .voltage_o   (voltage_o)
  );

  pws_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .step_index_i    (step_index_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .voltage_i       (voltage_o),
    .mismatch_count_o(fail_total),
    .pending_count_o (volts_pending)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Voltage consumer: the stall pattern is drawn at random from four styles, and one
  // long hold-off is taken on request so the pipeline fills and backs up.
  initial begin
    int style;
    int style_left;
    style      = 0;
    style_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(16, 128);
        end
        style_left--;
        case (style)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Write every register, with junk in the unused upper data bits.
  task automatic apply_setting(input logic m, input logic [VoltW-1:0] lo,
                               input logic [VoltW-1:0] hi, input logic [TickW-1:0] dly,
                               input logic [TickW-1:0] rs, input logic [TickW-1:0] fl,
                               input logic [TickW-1:0] on_t, input logic [TickW-1:0] per);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_MODE;   cfg_wdata_i <= {junk[CfgDataW-1:1], m};      @(posedge clk_i);
    cfg_index_i <= REG_V_LOW;  cfg_wdata_i <= {junk[CfgDataW-1:VoltW], lo}; @(posedge clk_i);
    cfg_index_i <= REG_V_HIGH; cfg_wdata_i <= {junk[CfgDataW-1:VoltW], hi}; @(posedge clk_i);
    cfg_index_i <= REG_DELAY;  cfg_wdata_i <= dly;                          @(posedge clk_i);
    cfg_index_i <= REG_RISE;   cfg_wdata_i <= rs;                           @(posedge clk_i);
    cfg_index_i <= REG_FALL;   cfg_wdata_i <= fl;                           @(posedge clk_i);
    cfg_index_i <= REG_ON;     cfg_wdata_i <= on_t;                         @(posedge clk_i);
    cfg_index_i <= REG_PERIOD; cfg_wdata_i <= per;                          @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_delay  = dly;
    cur_period = per;
  endtask

  // Offer one step index and hold it until the transfer; bursts of random
  // length are separated by random gaps.
  task automatic push_step(input logic [StepW-1:0] step);
    int gap;
    in_valid_i   <= 1'b1;
    step_index_i <= step;
    do @(posedge clk_i); while (!in_ready_o);
    steps_sent++;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80) : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Stop offering and wait until every predicted voltage has come back.
  task automatic end_phase();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (volts_pending != 0) @(posedge clk_i);
  endtask

  task automatic play_steps(input logic [StepW-1:0] list[$]);
    foreach (list[k]) push_step(list[k]);
    end_phase();
  endtask

  function automatic logic [VoltW-1:0] rand_level();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return VoltW'($urandom);
    endcase
  endfunction

  function automatic logic [TickW-1:0] rand_ticks();
    case ($urandom_range(0, 15))
      0:       return '1;
      1, 2:    return '0;
      default: return TickW'($urandom_range(1, 12));
    endcase
  endfunction

  // Most steps land in the first few periods after the delay.
  function automatic logic [StepW-1:0] pick_step();
    int unsigned reach;
    reach = (cur_period == 0) ? 40 : 3 * cur_period;
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return StepW'(cur_delay) - $urandom_range(1, 4);
      default: return StepW'(cur_delay) + $urandom_range(0, reach);
    endcase
  endfunction

  // Reset, directed cases, then random settings and steps.
  initial begin
    int               phase_no;
    int               phase_len;
    logic [TickW-1:0] dly;
    logic [TickW-1:0] per;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers at their reset values: DC at zero.
    play_steps('{32'd0, 32'hFFFF_FFFF});
    // DC mode ignores the pulse timing and gives the low level.
    apply_setting(1'b0, 16'h8000, 16'h7FFF, 24'd5, 24'd4, 24'd4, 24'd3, 24'd20);
    play_steps('{32'd12345, 32'h8000_0000});
    // Full-swing pulse: before the delay, rise, plateau, fall, low, wrap.
    apply_setting(1'b1, 16'h8000, 16'h7FFF, 24'd5, 24'd4, 24'd4, 24'd3, 24'd20);
    play_steps('{32'd4, 32'd5, 32'd7, 32'd9, 32'd12, 32'd14, 32'd16, 32'd24, 32'd25,
                 32'hFFFF_FFFF});
    // Instant edges with inverted levels.
    apply_setting(1'b1, 16'h7FFF, 16'h8000, 24'd0, 24'd0, 24'd0, 24'd2, 24'd5);
    play_steps('{32'd0, 32'd1, 32'd2, 32'd3});
    // Zero period gives the low level.
    apply_setting(1'b1, 16'h7FFF, 16'h8000, 24'd0, 24'd0, 24'd0, 24'd2, 24'd0);
    play_steps('{32'd7});
    // Segments running past the end of the period, with a falling ramp.
    apply_setting(1'b1, 16'd1000, 16'hFC18, 24'd0, 24'd10, 24'd10, 24'd10, 24'd15);
    play_steps('{32'd9, 32'd14});
    // Every timing register at its maximum.
    apply_setting(1'b1, 16'h8000, 16'h7FFF, '1, '1, '1, '1, '1);
    play_steps('{32'h00FF_FFFE, 32'hFFFF_FFFF, 32'h01FF_FFFD});

    // Random settings, each followed by a batch of steps.
    phase_no   = 0;
    steps_sent = 0;
    while (steps_sent < RandomItems) begin
      case ($urandom_range(0, 7))
        0:       dly = '1;
        1:       dly = TickW'($urandom);
        default: dly = TickW'($urandom_range(0, 30));
      endcase
      case ($urandom_range(0, 15))
        0:       per = '1;
        1:       per = '0;
        2, 3:    per = TickW'($urandom_range(1, 8));
        default: per = TickW'($urandom_range(8, 60));
      endcase
      apply_setting(($urandom_range(0, 4) != 0), rand_level(), rand_level(), dly,
                    rand_ticks(), rand_ticks(), rand_ticks(), per);
      phase_len = $urandom_range(20, 60);
      if (phase_no == 3) begin
        phase_len = 200;
        hold_req  = 1'b1;
      end
      repeat (phase_len) push_step(pick_step());
      end_phase();
      phase_no++;
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (volts_pending != 0) begin
      $error("voltage: %0d predicted results never arrived", volts_pending);
    end
    if (fail_total == 0 && volts_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: pulse_waveform_source.f
rtl/pws_pkg.sv
rtl/pws_rem_pipe.sv
rtl/pws_quo_pipe.sv
rtl/pulse_waveform_source.sv
verif/pws_checker.sv
verif/tb.sv
